// File: sv/start_length_end_frame_receiver_top_assert.svh
// Assertion macros for the frame receiver top level.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef START_LENGTH_END_FRAME_RECEIVER_TOP_ASSERT_SVH
`define START_LENGTH_END_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SLEFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slefr assertion failed");
// Next-cycle implication.
`define SLEFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slefr assertion failed");
`else
`define SLEFR_ASSERT_IMP(lbl, ante, cons)
`define SLEFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/slefr_pkg.sv
// Shared types, codes and constants for the start/length/end frame receiver.
// No dependencies.
package slefr_pkg;

  localparam int LEN_BYTES = 8;  // length field bytes, 1..8

  typedef logic [1:0] kind_t;
  typedef logic [2:0] phase_t;
  typedef logic [1:0] cfg_idx_t;

  localparam phase_t PH_HUNT    = 3'd0;
  localparam phase_t PH_LEN     = 3'd1;
  localparam phase_t PH_DATA    = 3'd2;
  localparam phase_t PH_END     = 3'd3;
  localparam phase_t PH_EXPIRED = 3'd4;

  localparam kind_t KIND_DATA    = 2'd0;
  localparam kind_t KIND_OK      = 2'd1;
  localparam kind_t KIND_BAD_END = 2'd2;
  localparam kind_t KIND_EXPIRED = 2'd3;

  localparam cfg_idx_t REG_START_PATTERN = 2'd0;
  localparam cfg_idx_t REG_END_PATTERN   = 2'd1;
  localparam cfg_idx_t REG_MAX_FRAME     = 2'd2;

  localparam logic [31:0] START_PATTERN_RST = 32'hFDFD_FDFD;
  localparam logic [31:0] END_PATTERN_RST   = 32'hFCFC_FCFC;
  localparam logic [31:0] MAX_FRAME_RST     = 32'h0100_0000;

  // Pick code byte idx of a 4-byte pattern, byte 0 first on the wire.
  function automatic logic [7:0] code_byte(input logic [31:0] pattern,
                                           input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = pattern[7:0];
      2'd1:    b = pattern[15:8];
      2'd2:    b = pattern[23:16];
      default: b = pattern[31:24];
    endcase
    return b;
  endfunction

endpackage

// File: sv/start_length_end_frame_receiver_top.sv
// Start/length/end frame receiver: start code hunt, length gather, payload pass,
// end code check. Depends on slefr_pkg and start_length_end_frame_receiver_top_assert.svh.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+----------------------------
//  in      | in_valid, in_ready, in_rx_byte          | one received byte per request
//  out     | out_valid, out_ready, out_kind, ...     | zero or one result per byte
//  cfg     | cfg_wr_en, cfg_index, cfg_wr_data       | register write, no wait
//
// One byte is accepted per cycle while in_ready is high; its result sits in the output
// register the next cycle. The frame state updates in the accepting cycle.
// in_ready is low only while a result waits in the output register and out_ready is low.
// Synchronous active-low reset returns to start code hunt with reset register values.
`include "start_length_end_frame_receiver_top_assert.svh"

module start_length_end_frame_receiver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output slefr_pkg::kind_t    out_kind,
  output logic [7:0]          out_payload_byte,
  output logic [31:0]         out_frame_length,
  input  logic                cfg_wr_en,
  input  slefr_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]         cfg_wr_data
);
  import slefr_pkg::*;

  localparam logic [2:0] LEN_DONE = 3'(LEN_BYTES % 8);

  logic [31:0] start_r, end_r, max_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] decl_r, decl_nxt;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_len_r;

  logic        in_fire;
  logic        res_v;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic [31:0] res_len;

  logic [63:0] acc_sh;
  logic [2:0]  cnt_inc;
  logic        hi_nz;
  logic        oversize;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Length byte merge and oversize check.
  assign acc_sh   = acc_r | ({56'd0, in_rx_byte} << {cnt_r, 3'b000});
  assign cnt_inc  = cnt_r + 3'd1;
  assign hi_nz    = |acc_sh[63:32];
  assign oversize = hi_nz || (acc_sh[31:0] > max_r);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    decl_nxt  = decl_r;
    res_v     = 1'b0;
    res_kind  = KIND_DATA;
    res_byte  = 8'd0;
    res_len   = decl_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_EXPIRED: begin
          // drop every byte until reset
        end
        PH_LEN: begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_inc;
          if (cnt_inc == LEN_DONE) begin
            if (oversize) begin
              phase_nxt = PH_EXPIRED;
              res_v     = 1'b1;
              res_kind  = KIND_EXPIRED;
              res_len   = hi_nz ? 32'hFFFF_FFFF : acc_sh[31:0];
            end else begin
              decl_nxt  = acc_sh[31:0];
              rem_nxt   = acc_sh[31:0];
              idx_nxt   = 2'd0;
              phase_nxt = (acc_sh[31:0] == 32'd0) ? PH_END : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          rem_nxt  = rem_r - 32'd1;
          res_v    = 1'b1;
          res_kind = KIND_DATA;
          res_byte = in_rx_byte;
          if (rem_r == 32'd1) begin
            phase_nxt = PH_END;
            idx_nxt   = 2'd0;
          end
        end
        PH_END: begin
          if (in_rx_byte != code_byte(end_r, idx_r)) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = 2'd0;
            res_v     = 1'b1;
            res_kind  = KIND_BAD_END;
          end else if (idx_r == 2'd3) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = 2'd0;
            res_v     = 1'b1;
            res_kind  = KIND_OK;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        default: begin
          // start code hunt; unused codes fall in here too
          if (in_rx_byte != code_byte(start_r, idx_r)) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = 2'd0;
          end else if (idx_r == 2'd3) begin
            phase_nxt = PH_LEN;
            idx_nxt   = 2'd0;
            acc_nxt   = 64'd0;
            cnt_nxt   = 3'd0;
          end else begin
            phase_nxt = PH_HUNT;
            idx_nxt   = idx_r + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= 2'd0;
      acc_r   <= 64'd0;
      cnt_r   <= 3'd0;
      rem_r   <= 32'd0;
      decl_r  <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      decl_r  <= decl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_PATTERN_RST;
      end_r   <= END_PATTERN_RST;
      max_r   <= MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_PATTERN: start_r <= cfg_wr_data;
        REG_END_PATTERN:   end_r   <= cfg_wr_data;
        REG_MAX_FRAME:     max_r   <= cfg_wr_data;
        default: begin
          // no register at this index: drop the write
        end
      endcase
    end
  end

  // Output register: load on an accepted byte, clear once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_v;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_v) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_len_r  <= res_len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_length = out_len_r;

  `SLEFR_ASSERT_NXT(a_expired_sticky, phase_r == PH_EXPIRED, phase_r == PH_EXPIRED)
  `SLEFR_ASSERT_IMP(a_data_nonzero_rem, phase_r == PH_DATA, rem_r != 32'd0)
  `SLEFR_ASSERT_IMP(a_byte_only_data, out_valid_r && out_kind_r != KIND_DATA, out_byte_r == 8'd0)
  `SLEFR_ASSERT_NXT(a_expired_no_result, phase_r == PH_EXPIRED && in_fire, !out_valid_r)

endmodule

// File: verif/tb_start_length_end_frame_receiver_top.sv
// Self-checking bench for start_length_end_frame_receiver_top: sends framed and noisy byte
// streams, predicts every result in a local deframer and compares it field by field.
// Depends on slefr_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb_start_length_end_frame_receiver_top;
  import slefr_pkg::*;

  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] flen;
  } frame_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_ready   = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  cfg_idx_t    cfg_index   = REG_START_PATTERN;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_ready;
  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_payload_byte;
  logic [31:0] out_frame_length;

  // deframer state and register shadows
  phase_t      fr_phase     = PH_HUNT;
  logic [1:0]  fr_code_idx  = 2'd0;
  logic [63:0] fr_len_acc   = 64'd0;
  logic [2:0]  fr_len_cnt   = 3'd0;
  logic [31:0] fr_remaining = 32'd0;
  logic [31:0] fr_length    = 32'd0;
  logic [31:0] sh_sof_pat   = START_PATTERN_RST;
  logic [31:0] sh_eof_pat   = END_PATTERN_RST;
  logic [31:0] sh_max_len   = MAX_FRAME_RST;

  frame_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   sent_items = 0;
  int unsigned   rx_hold    = 0;
  bit            steady     = 1'b0;

  start_length_end_frame_receiver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Advance the deframer by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    case (fr_phase)
      PH_EXPIRED: ;
      PH_LEN: begin
        fr_len_acc = fr_len_acc | (64'(b) << {fr_len_cnt, 3'b000});
        fr_len_cnt = fr_len_cnt + 3'd1;
        if (fr_len_cnt == 3'(LEN_BYTES)) begin
          if (fr_len_acc > {32'd0, sh_max_len}) begin
            fr_phase = PH_EXPIRED;
            res = '{KIND_EXPIRED, 8'h00,
                    (fr_len_acc[63:32] != 0) ? 32'hFFFF_FFFF : fr_len_acc[31:0]};
            hit = 1'b1;
          end else begin
            fr_length    = fr_len_acc[31:0];
            fr_remaining = fr_length;
            fr_code_idx  = 2'd0;
            fr_phase     = (fr_remaining == 0) ? PH_END : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        fr_remaining = fr_remaining - 32'd1;
        if (fr_remaining == 0) begin
          fr_phase    = PH_END;
          fr_code_idx = 2'd0;
        end
        res = '{KIND_DATA, b, fr_length};
        hit = 1'b1;
      end
      PH_END: begin
        if (b != sh_eof_pat[{fr_code_idx, 3'b000} +: 8]) begin
          fr_phase    = PH_HUNT;
          fr_code_idx = 2'd0;
          res = '{KIND_BAD_END, 8'h00, fr_length};
          hit = 1'b1;
        end else if (fr_code_idx == 2'd3) begin
          fr_phase    = PH_HUNT;
          fr_code_idx = 2'd0;
          res = '{KIND_OK, 8'h00, fr_length};
          hit = 1'b1;
        end else begin
          fr_code_idx = fr_code_idx + 2'd1;
        end
      end
      default: begin
        // a mismatching byte is dropped, never retried as the first code byte
        if (b != sh_sof_pat[{fr_code_idx, 3'b000} +: 8]) begin
          fr_phase    = PH_HUNT;
          fr_code_idx = 2'd0;
        end else if (fr_code_idx == 2'd3) begin
          fr_phase    = PH_LEN;
          fr_code_idx = 2'd0;
          fr_len_acc  = 64'd0;
          fr_len_cnt  = 3'd0;
        end else begin
          fr_code_idx = fr_code_idx + 2'd1;
        end
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin : result_monitor
    frame_result_t got;
    frame_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_payload_byte, out_frame_length};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: kind %0d byte %02h length %08h",
                     $time, got.kind, got.data, got.flen);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp/act: kind %0d/%0d byte %02h/%02h len %08h/%08h",
                       $time, want.kind, got.kind, want.data, got.data, want.flen, got.flen);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(in_rx_byte, want))
          pending_results = {pending_results, want};
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_PATTERN: sh_sof_pat = cfg_wr_data;
          REG_END_PATTERN:   sh_eof_pat = cfg_wr_data;
          REG_MAX_FRAME:     sh_max_len = cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver side: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] sof_pat, input logic [31:0] eof_pat,
                          input logic [31:0] max_len);
    drain();
    write_reg(REG_START_PATTERN, sof_pat);
    write_reg(REG_END_PATTERN, eof_pat);
    write_reg(REG_MAX_FRAME, max_len);
  endtask

  // Any byte that cannot advance the start code match.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == sh_sof_pat[7:0] || b == sh_sof_pat[15:8] ||
           b == sh_sof_pat[23:16] || b == sh_sof_pat[31:24]);
    return b;
  endfunction

  task automatic send_header(input logic [63:0] len);
    int i;
    for (i = 0; i < 4; i++) send_byte(sh_sof_pat[8*i +: 8]);
    for (i = 0; i < LEN_BYTES; i++) send_byte(len[8*i +: 8]);
  endtask

  // Full frame; with bad_end one end code byte is replaced and the frame stops there.
  task automatic send_frame(input logic [31:0] len, input bit bad_end);
    int unsigned i;
    int unsigned bad_at;
    logic [7:0]  good;
    logic [7:0]  bad;
    bad_at = $urandom_range(3);
    send_header({32'd0, len});
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
    for (i = 0; i < 4; i++) begin
      good = sh_eof_pat[8*i +: 8];
      if (bad_end && i == bad_at) begin
        bad = $urandom_range(1) ? sh_sof_pat[7:0] : 8'($urandom_range(255));
        if (bad == good) bad = good ^ 8'h5A;
        send_byte(bad);
        break;
      end
      send_byte(good);
    end
  endtask

  // Reset registers: two payload extremes, then a bad third end code byte.
  task automatic test_bad_end_defaults();
    send_header(64'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sh_eof_pat[7:0]);
    send_byte(sh_eof_pat[15:8]);
    send_byte(sh_sof_pat[7:0]);
  endtask

  // Broken start code whose failing byte equals the first code byte, then an empty frame.
  task automatic test_start_hunt();
    set_regs(32'h0403_0201, END_PATTERN_RST, MAX_FRAME_RST);
    send_byte(sh_sof_pat[7:0]);
    send_byte(sh_sof_pat[15:8]);
    send_byte(sh_sof_pat[7:0]);
    send_byte(sh_sof_pat[15:8]);
    send_byte(sh_sof_pat[23:16]);
    send_byte(sh_sof_pat[31:24]);
    send_frame(32'd0, 1'b0);
  endtask

  task automatic test_unused_register();
    drain();
    write_reg(REG_UNUSED, $urandom());
    send_frame(32'($urandom_range(6)), 1'b0);
  endtask

  // Hold the receiver off while a long payload keeps coming, so the input stalls.
  task automatic test_backpressure();
    set_regs($urandom(), $urandom(), 32'd64);
    rx_hold = 150;
    send_frame(32'd48, 1'b0);
    drain();
  endtask

  task automatic test_random_frames(input logic [31:0] sof_pat, input logic [31:0] eof_pat,
                                    input logic [31:0] max_len, input int unsigned n_bytes);
    int unsigned target;
    int unsigned k;
    int unsigned i;
    logic [31:0] cap;
    logic [31:0] len;
    set_regs(sof_pat, eof_pat, max_len);
    target = sent_items + n_bytes;
    cap = (sh_max_len < 32'd24) ? sh_max_len : 32'd24;
    while (sent_items < target) begin
      repeat ($urandom_range(3)) send_byte(noise_byte());
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(3, 1);
        for (i = 0; i < k; i++) send_byte(sh_sof_pat[8*i +: 8]);
        send_byte(noise_byte());
      end
      len = $urandom_range(cap);
      if ($urandom_range(7) == 0) len = cap;
      send_frame(len, $urandom_range(99) < 15);
    end
  endtask

  // Oversize length locks the link; nothing after it may produce a result.
  task automatic test_expired_link();
    logic [63:0] len;
    logic [31:0] upper;
    if ($urandom_range(1)) begin
      set_regs($urandom(), $urandom(), 32'hFFFF_FFFF);
      upper = $urandom();
      if (upper == 0) upper = 32'd1;
      len = {upper, 32'($urandom())};
    end else begin
      set_regs($urandom(), $urandom(), 32'($urandom_range(1000)));
      len = 64'(sh_max_len) + 64'($urandom_range(300, 1));
    end
    send_header(len);
    send_frame(32'd0, 1'b0);
    repeat (16) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_bad_end_defaults();
    test_start_hunt();
    test_unused_register();
    test_backpressure();
    test_random_frames($urandom(), $urandom(), 32'hFFFF_FFFF, 270);
    test_random_frames(32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 220);
    test_random_frames(32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom_range(30, 1)), 270);
    steady = 1'b1;
    test_random_frames($urandom(), $urandom(), 32'($urandom_range(5000, 24)), 270);
    steady = 1'b0;
    test_random_frames(START_PATTERN_RST, END_PATTERN_RST, MAX_FRAME_RST, 270);
    test_expired_link();
    drain();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
